FILE: sv/vertex_weld_indexer_assert.svh
// assertion macros shared by the vertex weld indexer checkers
// no dependencies; expects clk and rst_n in the scope of use
`ifndef VERTEX_WELD_INDEXER_ASSERT_SVH
`define VERTEX_WELD_INDEXER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define VWI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define VWI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/vwi_pkg.sv
// shared constants, types and control structs for the vertex weld indexer
// no dependencies; used by vwi_dist, vertex_weld_indexer and vwi_checker
package vwi_pkg;

    // table and field geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int COORD_BITS  = 20;
    localparam int NUM_COMP    = 4;
    localparam int TOL_W       = 20;
    localparam int VIDX_W      = 10;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int PH_W   = $clog2(NUM_COMP);

    // arithmetic widths of the distance unit
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int MUL_W  = (COORD_BITS > TOL_W) ? COORD_BITS : TOL_W;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = PROD_W + PH_W;

    // stream widths
    localparam int VTX_W         = NUM_COMP * COORD_BITS;
    localparam int IN_TDATA_W    = ((VTX_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = ((VIDX_W + 7) / 8) * 8;

    typedef logic [NUM_COMP-1:0][COORD_BITS-1:0] vertex_t;

    // one component pair sent to the distance unit
    typedef struct packed {
        logic                  valid;
        logic                  first;
        logic                  last;
        logic [ADDR_W-1:0]     idx;
        logic [COORD_BITS-1:0] a;
        logic [COORD_BITS-1:0] b;
    } dist_req_t;

    // sequencer control of the distance unit
    typedef struct packed {
        logic flush;
        logic calc_lim;
    } dist_ctl_t;

    // distance unit status back to the sequencer
    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] idx;
        logic              busy;
    } dist_rsp_t;

endpackage

FILE: sv/vwi_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module vwi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/vwi_dist.sv
// pipelined squared-distance unit with one shared squarer
// one vertex component per cycle; also squares the tolerance into the limit
// depends on vwi_pkg
module vwi_dist (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [vwi_pkg::TOL_W-1:0]    tol,
    input  vwi_pkg::dist_ctl_t           ctl,
    input  vwi_pkg::dist_req_t           req,
    output vwi_pkg::dist_rsp_t           rsp
);

    // stage 1: component difference
    logic                              s1_v_reg;
    logic                              s1_first_reg;
    logic                              s1_last_reg;
    logic [vwi_pkg::ADDR_W-1:0]        s1_idx_reg;
    logic [vwi_pkg::DIFF_W-1:0]        s1_d_reg;

    // stage 2: magnitude and early reject
    logic                              s2_v_reg;
    logic                              s2_first_reg;
    logic                              s2_last_reg;
    logic [vwi_pkg::ADDR_W-1:0]        s2_idx_reg;
    logic [vwi_pkg::COORD_BITS-1:0]    s2_m_reg;
    logic                              s2_far_reg;

    // stage 3: square
    logic                              s3_v_reg;
    logic                              s3_first_reg;
    logic                              s3_last_reg;
    logic [vwi_pkg::ADDR_W-1:0]        s3_idx_reg;
    logic [vwi_pkg::PROD_W-1:0]        s3_sq_reg;
    logic                              s3_far_reg;

    // stage 4: accumulate and decide
    logic [vwi_pkg::ACC_W-1:0]         acc_reg;
    logic                              rej_reg;
    logic                              hit_reg;
    logic [vwi_pkg::ADDR_W-1:0]        hit_idx_reg;
    logic [vwi_pkg::PROD_W-1:0]        lim_reg;

    logic [vwi_pkg::DIFF_W-1:0]        mag_full;
    logic [vwi_pkg::COORD_BITS-1:0]    mag;
    logic [vwi_pkg::MUL_W-1:0]         mul_op;
    logic [vwi_pkg::PROD_W-1:0]        prod;
    logic [vwi_pkg::ACC_W-1:0]         acc_next;
    logic                              rej_next;
    logic                              match;

    // absolute difference fits the coordinate width
    assign mag_full = s1_d_reg[vwi_pkg::DIFF_W-1] ? (~s1_d_reg + 1'b1) : s1_d_reg;
    assign mag      = mag_full[vwi_pkg::COORD_BITS-1:0];

    // shared squarer: tolerance while idle or loading, else the stage 2 magnitude
    assign mul_op = ctl.calc_lim ? vwi_pkg::MUL_W'(tol) : vwi_pkg::MUL_W'(s2_m_reg);
    assign prod   = vwi_pkg::PROD_W'(mul_op) * vwi_pkg::PROD_W'(mul_op);

    // running sum over the four components of one entry
    assign acc_next = (s3_first_reg ? '0 : acc_reg) + vwi_pkg::ACC_W'(s3_sq_reg);
    assign rej_next = (s3_first_reg ? 1'b0 : rej_reg) | s3_far_reg;
    assign match    = !rej_next && (acc_next < vwi_pkg::ACC_W'(lim_reg));

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            s1_v_reg <= req.valid && !ctl.flush;
            s2_v_reg <= s1_v_reg && !ctl.flush;
            s3_v_reg <= s2_v_reg && !ctl.flush;
            hit_reg  <= s3_v_reg && s3_last_reg && match && !ctl.flush;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        s1_first_reg <= req.first;
        s1_last_reg  <= req.last;
        s1_idx_reg   <= req.idx;
        s1_d_reg     <= {req.a[vwi_pkg::COORD_BITS-1], req.a}
                        - {req.b[vwi_pkg::COORD_BITS-1], req.b};

        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_idx_reg   <= s1_idx_reg;
        s2_m_reg     <= mag;
        s2_far_reg   <= vwi_pkg::MUL_W'(mag) >= vwi_pkg::MUL_W'(tol);

        s3_first_reg <= s2_first_reg;
        s3_last_reg  <= s2_last_reg;
        s3_idx_reg   <= s2_idx_reg;
        s3_sq_reg    <= prod;
        s3_far_reg   <= s2_far_reg;

        if (s3_v_reg)
        begin
            acc_reg <= acc_next;
            rej_reg <= rej_next;
        end
        hit_idx_reg <= s3_idx_reg;

        if (ctl.calc_lim)
        begin
            lim_reg <= prod;
        end
    end

    assign rsp.hit  = hit_reg;
    assign rsp.idx  = hit_idx_reg;
    assign rsp.busy = s1_v_reg | s2_v_reg | s3_v_reg | hit_reg;

endmodule

FILE: sv/vertex_weld_indexer.sv
// vertex weld indexer
//
// channels: the slave stream takes one vertex per request (s_tdata holds
// pos_x, pos_y, pos_z, pos_w from the lowest bit up, s_tuser is
// start_of_mesh); the master stream returns one result per vertex
// (vertex_index in m_tdata, is_new and table_overflow in m_tuser).
// the user must write tolerance through cfg_wr_en / cfg_wr_data only
// while idle; the block does not enforce this. each vertex is compared
// against the N stored unique entries in order, one component per cycle
// through a single shared squarer, and the next request is taken only
// once the result has been handed on to the output register.
// reset empties the table (entry count to zero) and sets tolerance to 1;
// table contents are not cleared, entries past the count are never read.
// when the receiver stalls, the result is held in the output register and
// one more request may be scanned; the block then waits with that result
// until the output register frees.
// depends on vwi_pkg, vwi_ram, vwi_dist
module vertex_weld_indexer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [vwi_pkg::TOL_W-1:0]          cfg_wr_data,   // tolerance
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [vwi_pkg::IN_TDATA_W-1:0]     s_tdata,       // pos_x, pos_y, pos_z, pos_w
    input  logic [0:0]                         s_tuser,       // start_of_mesh
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [vwi_pkg::OUT_TDATA_W-1:0]    m_tdata,       // vertex_index
    output logic [1:0]                         m_tuser        // is_new, table_overflow
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic [vwi_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [vwi_pkg::ADDR_W-1:0]      iss_reg, iss_next;
    logic [vwi_pkg::PH_W-1:0]        ph_reg, ph_next;
    logic [vwi_pkg::TOL_W-1:0]       tol_reg, tol_next;
    vwi_pkg::vertex_t                vtx_reg, vtx_next;
    logic [vwi_pkg::VIDX_W-1:0]      res_idx_reg, res_idx_next;
    logic                            res_new_reg, res_new_next;
    logic                            res_ovf_reg, res_ovf_next;
    logic                            out_v_reg, out_v_next;
    logic [vwi_pkg::VIDX_W-1:0]      out_idx_reg, out_idx_next;
    logic                            out_new_reg, out_new_next;
    logic                            out_ovf_reg, out_ovf_next;

    logic                            rd_en;
    logic [vwi_pkg::ADDR_W-1:0]      rd_addr;
    logic [vwi_pkg::VTX_W-1:0]       rd_data;
    vwi_pkg::vertex_t                rd_vtx;
    logic                            wr_en;
    vwi_pkg::dist_req_t              dreq;
    vwi_pkg::dist_ctl_t              dctl;
    vwi_pkg::dist_rsp_t              drsp;
    logic                            last_entry;
    logic                            last_comp;

    // unique vertex table, all four components in one word
    vwi_ram #(
        .WIDTH (vwi_pkg::VTX_W),
        .DEPTH (vwi_pkg::TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[vwi_pkg::ADDR_W-1:0]),
        .wr_data (vtx_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    vwi_dist u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .tol   (tol_reg),
        .ctl   (dctl),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign rd_vtx     = rd_data;
    assign last_comp  = (ph_reg == vwi_pkg::PH_W'(vwi_pkg::NUM_COMP - 1));
    assign last_entry = ((vwi_pkg::CNT_W'(iss_reg) + vwi_pkg::CNT_W'(1)) == cnt_reg);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        iss_next     = iss_reg;
        ph_next      = ph_reg;
        tol_next     = tol_reg;
        vtx_next     = vtx_reg;
        res_idx_next = res_idx_reg;
        res_new_next = res_new_reg;
        res_ovf_next = res_ovf_reg;
        out_v_next   = out_v_reg;
        out_idx_next = out_idx_reg;
        out_new_next = out_new_reg;
        out_ovf_next = out_ovf_reg;

        rd_en   = 1'b0;
        rd_addr = iss_reg + vwi_pkg::ADDR_W'(1);
        wr_en   = 1'b0;

        dreq.valid = 1'b0;
        dreq.first = (ph_reg == '0);
        dreq.last  = last_comp;
        dreq.idx   = iss_reg;
        dreq.a     = rd_vtx[ph_reg];
        dreq.b     = vtx_reg[ph_reg];

        dctl.flush    = 1'b0;
        dctl.calc_lim = (state_reg == ST_IDLE) || (state_reg == ST_LOAD);

        // tolerance register
        if (cfg_wr_en)
        begin
            tol_next = cfg_wr_data;
        end

        // output register drains when its result is taken
        if (out_v_reg && m_tready)
        begin
            out_v_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    vtx_next = s_tdata[vwi_pkg::VTX_W-1:0];
                    if (s_tuser[0])
                    begin
                        cnt_next = '0;
                    end
                    state_next = ST_LOAD;
                end
            end

            // fetch entry 0 if the table is not empty, and square the tolerance
            ST_LOAD:
            begin
                iss_next = '0;
                ph_next  = '0;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = ST_SCAN;
                end
            end

            // one component per cycle, next entry fetched on the last one
            ST_SCAN:
            begin
                if (drsp.hit)
                begin
                    dctl.flush   = 1'b1;
                    res_idx_next = vwi_pkg::VIDX_W'(drsp.idx);
                    res_new_next = 1'b0;
                    res_ovf_next = 1'b0;
                    state_next   = ST_DONE;
                end
                else
                begin
                    dreq.valid = 1'b1;
                    ph_next    = ph_reg + vwi_pkg::PH_W'(1);
                    if (last_comp)
                    begin
                        if (last_entry)
                        begin
                            state_next = ST_DRAIN;
                        end
                        else
                        begin
                            rd_en    = 1'b1;
                            iss_next = iss_reg + vwi_pkg::ADDR_W'(1);
                        end
                    end
                end
            end

            // wait for the pipeline, taking a late match, else append or flag overflow
            ST_DRAIN:
            begin
                if (drsp.hit)
                begin
                    dctl.flush   = 1'b1;
                    res_idx_next = vwi_pkg::VIDX_W'(drsp.idx);
                    res_new_next = 1'b0;
                    res_ovf_next = 1'b0;
                    state_next   = ST_DONE;
                end
                else if (!drsp.busy)
                begin
                    if (cnt_reg >= vwi_pkg::CNT_W'(vwi_pkg::TABLE_DEPTH))
                    begin
                        res_idx_next = '0;
                        res_new_next = 1'b0;
                        res_ovf_next = 1'b1;
                    end
                    else
                    begin
                        wr_en        = 1'b1;
                        res_idx_next = vwi_pkg::VIDX_W'(cnt_reg[vwi_pkg::ADDR_W-1:0]);
                        res_new_next = 1'b1;
                        res_ovf_next = 1'b0;
                        cnt_next     = cnt_reg + vwi_pkg::CNT_W'(1);
                    end
                    state_next = ST_DONE;
                end
            end

            // hand the result to the output register once it is free
            ST_DONE:
            begin
                if (!out_v_reg || m_tready)
                begin
                    out_v_next   = 1'b1;
                    out_idx_next = res_idx_reg;
                    out_new_next = res_new_reg;
                    out_ovf_next = res_ovf_reg;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            iss_reg   <= '0;
            ph_reg    <= '0;
            tol_reg   <= vwi_pkg::TOL_W'(1);
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            iss_reg   <= iss_next;
            ph_reg    <= ph_next;
            tol_reg   <= tol_next;
            out_v_reg <= out_v_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        vtx_reg     <= vtx_next;
        res_idx_reg <= res_idx_next;
        res_new_reg <= res_new_next;
        res_ovf_reg <= res_ovf_next;
        out_idx_reg <= out_idx_next;
        out_new_reg <= out_new_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_v_reg;
    assign m_tdata  = vwi_pkg::OUT_TDATA_W'(out_idx_reg);
    assign m_tuser  = {out_ovf_reg, out_new_reg};

endmodule

FILE: sv/vwi_checker.sv
// port-level checker for the vertex weld indexer, bound to the top level
// depends on vwi_pkg and vertex_weld_indexer_assert.svh
`include "vertex_weld_indexer_assert.svh"

module vwi_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [vwi_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic [1:0]                         m_tuser
);

    // a result is never both new and overflowed
    `VWI_ASSERT_NOW(a_flags_excl, m_tvalid, !(m_tuser[0] && m_tuser[1]), "new and overflow both set")

    // an overflow result carries index zero
    `VWI_ASSERT_NOW(a_ovf_idx, m_tvalid && m_tuser[1], m_tdata == '0, "overflow with nonzero index")

    // one request at a time: not ready right after a request is taken
    `VWI_ASSERT_NXT(a_one_req, s_tvalid && s_tready, !s_tready, "ready right after a request")

    // a stalled result holds
    `VWI_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind vertex_weld_indexer vwi_checker u_vwi_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
